[hdl/circular_deque_with_rotate_defines.svh]
// assertion macros for the circular deque checker
`ifndef CIRCULAR_DEQUE_WITH_ROTATE_DEFINES_SVH
`define CIRCULAR_DEQUE_WITH_ROTATE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CDR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cdr_pkg.sv]
// shared constants and types for the circular deque with rotate
package cdr_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STEP_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned BIT_W  = $clog2(STEP_W);

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_ROT  = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_ROT  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic push;
    logic shift;
    logic rot;
  } cdr_cell_cmd_t;

endpackage

[hdl/cdr_cell.sv]
// one storage cell of the deque chain
module cdr_cell
  import cdr_pkg::*;
(
  input  logic                     clk_i,
  input  cdr_cell_cmd_t            cmd_i,
  input  logic                     sel_i,
  input  logic signed [DATA_W-1:0] next_i,
  input  logic signed [DATA_W-1:0] front_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic signed [DATA_W-1:0] data_o
);

  logic signed [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.push && sel_i) begin
      data_d = push_value_i;
    end else if (cmd_i.shift) begin
      // the tail cell catches the front value on a rotate step
      data_d = (cmd_i.rot && sel_i) ? front_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[hdl/cdr_mod.sv]
// bit-serial remainder unit for the rotate step
module cdr_mod
  import cdr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [STEP_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [CNT_W-1:0]  rem_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [STEP_W-1:0] dvd_q, dvd_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[STEP_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // one dividend bit per cycle, msb first
      if (trial >= {1'b0, dsr_q}) begin
        trial = trial - {1'b0, dsr_q};
      end
      rem_d = trial[CNT_W-1:0];
      dvd_d = {dvd_q[STEP_W-2:0], 1'b0};
      bit_d = bit_q + BIT_W'(1);
      if (bit_q == BIT_W'(STEP_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[hdl/circular_deque_with_rotate.sv]
// circular deque with rotate: chain of value cells, remainder unit, control
//
// Input channel (in_valid_i / in_ready_o) takes one item: kind_i selects push at
// the back, pop at the front, rotate, or no operation. Every item gives exactly
// one result on the output channel (out_valid_o / out_ready_i): popped value,
// status and occupancy after the operation.
// Values sit in a row of cells, cell 0 holding the front. A pop shifts every cell
// of the row toward the front at once; a push loads the cell just past the tail.
// Push, pop and no-op results pass from the result registers in S_DONE to the
// output register, and the control then returns to idle for the next item.
// A rotate on a non-empty deque first reduces its step modulo the occupancy in
// a bit-serial unit, then moves k values from front to tail, one per cycle, with
// k the reduced forward distance (below the occupancy); its result then passes
// through S_DONE to the output register like the others.
// One item is in work at a time; in_ready_o is high only while idle, and the
// output register lets the next item be accepted while a result waits.
// When the receiver stalls, a finished result holds in the control until the
// output register is free.
// Reset empties the deque (occupancy 0); cell contents are left as they are.
module circular_deque_with_rotate
  import cdr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               kind_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  input  logic signed [STEP_W-1:0] rotate_step_i,
  input  logic                     rotate_backward_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] popped_value_o,
  output logic [1:0]               status_o,
  output logic [CNT_W-1:0]         occupancy_o
);

  state_e                   st_q, st_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         k_q, k_d;
  logic                     bwd_q, bwd_d;
  logic signed [DATA_W-1:0] res_pop_q, res_pop_d;
  status_e                  res_stat_q, res_stat_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_pop_q, out_pop_d;
  status_e                  out_stat_q, out_stat_d;
  logic [CNT_W-1:0]         out_occ_q, out_occ_d;

  cdr_cell_cmd_t            cmd;
  logic                     mod_start;
  logic                     mod_done;
  logic [CNT_W-1:0]         mod_rem;
  logic [STEP_W-1:0]        mag;
  logic                     accept;
  logic                     out_free;
  logic [CNT_W-1:0]         tail;
  logic [IDX_W-1:0]         tgt;
  logic [DEPTH-1:0]         sel;
  logic signed [DATA_W-1:0] cell_data [DEPTH];

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign mag      = rotate_step_i[STEP_W-1] ? (~rotate_step_i + STEP_W'(1)) : rotate_step_i;

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    bwd_d      = bwd_q;
    res_pop_d  = res_pop_q;
    res_stat_d = res_stat_q;
    cmd        = '0;
    mod_start  = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          res_pop_d  = '0;
          res_stat_d = STAT_OK;
          st_d       = S_DONE;
          unique case (kind_e'(kind_i))
            KIND_PUSH: begin
              if (cnt_q == CNT_W'(DEPTH)) begin
                res_stat_d = STAT_FULL;
              end else begin
                cmd.push = 1'b1;
                cnt_d    = cnt_q + CNT_W'(1);
              end
            end
            KIND_POP: begin
              if (cnt_q == '0) begin
                res_pop_d  = '1;
                res_stat_d = STAT_EMPTY;
              end else begin
                res_pop_d = cell_data[0];
                cmd.shift = 1'b1;
                cnt_d     = cnt_q - CNT_W'(1);
              end
            end
            KIND_ROT: begin
              if (cnt_q != '0) begin
                mod_start = 1'b1;
                bwd_d     = rotate_backward_i ^ rotate_step_i[STEP_W-1];
                st_d      = S_MOD;
              end
            end
            KIND_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          // a backward move by r is a forward move by occupancy - r
          k_d  = (bwd_q && mod_rem != '0) ? (cnt_q - mod_rem) : mod_rem;
          st_d = S_ROT;
        end
      end
      S_ROT: begin
        if (k_q == '0) begin
          st_d = S_DONE;
        end else begin
          cmd.shift = 1'b1;
          cmd.rot   = 1'b1;
          k_d       = k_q - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_pop_d   = out_pop_q;
    out_stat_d  = out_stat_q;
    out_occ_d   = out_occ_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (st_q == S_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_pop_d   = res_pop_q;
      out_stat_d  = res_stat_q;
      out_occ_d   = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      bwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      bwd_q       <= bwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_pop_q  <= res_pop_d;
    res_stat_q <= res_stat_d;
    out_pop_q  <= out_pop_d;
    out_stat_q <= out_stat_d;
    out_occ_q  <= out_occ_d;
  end

  // push writes just past the tail, a rotate step writes the tail itself
  assign tail = cnt_q - CNT_W'(1);
  assign tgt  = cmd.push ? cnt_q[IDX_W-1:0] : tail[IDX_W-1:0];

  cdr_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mag),
    .divisor_i  (cnt_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] next_val;

    assign sel[i] = (tgt == IDX_W'(i));

    if (i < DEPTH - 1) begin : g_mid
      assign next_val = cell_data[i+1];
    end else begin : g_last
      assign next_val = cell_data[i];
    end

    cdr_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .sel_i        (sel[i]),
      .next_i       (next_val),
      .front_i      (cell_data[0]),
      .push_value_i (push_value_i),
      .data_o       (cell_data[i])
    );
  end

  assign in_ready_o     = (st_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_pop_q;
  assign status_o       = out_stat_q;
  assign occupancy_o    = out_occ_q;

endmodule

[hdl/cdr_checker.sv]
// port-level checks for the circular deque with rotate, bound to the top level
`include "circular_deque_with_rotate_defines.svh"

module cdr_checker
  import cdr_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] popped_value_o,
  input logic [1:0]               status_o,
  input logic [CNT_W-1:0]         occupancy_o
);

  logic                          in_take;
  logic                          out_stall;
  logic                          full_res;
  logic                          empty_res;
  logic                          full_ok;
  logic                          empty_ok;
  logic [DATA_W+2+CNT_W-1:0]     out_bits;

  assign in_take   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign full_res  = out_valid_o && status_o == STAT_FULL;
  assign empty_res = out_valid_o && status_o == STAT_EMPTY;
  assign full_ok   = occupancy_o == CNT_W'(DEPTH) && popped_value_o == '0;
  assign empty_ok  = occupancy_o == '0 && popped_value_o == '1;
  assign out_bits  = {popped_value_o, status_o, occupancy_o};

  `CDR_ASSERT(a_occ_range, out_valid_o, occupancy_o <= CNT_W'(DEPTH), "occupancy above depth")
  `CDR_ASSERT(a_full_res, full_res, full_ok, "full result inconsistent")
  `CDR_ASSERT(a_empty_res, empty_res, empty_ok, "empty result inconsistent")
  `CDR_ASSERT_NEXT(a_one_at_a_time, in_take, !in_ready_o, "item taken while one is in work")
  `CDR_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_bits), "stalled result changed")

endmodule

bind circular_deque_with_rotate cdr_checker u_checker (.*);

[test/tb_circular_deque_with_rotate.sv]
`timescale 1ns / 100ps
// testbench for the circular deque with rotate: random and directed items against a queue model
module tb_circular_deque_with_rotate;
  import cdr_pkg::*;

  typedef struct packed {
    kind_e                    kind;
    logic signed [DATA_W-1:0] push_v;
    logic signed [STEP_W-1:0] step;
    logic                     back;
  } deque_op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    status_e                  status;
    logic [CNT_W-1:0]         occ;
  } deque_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               kind_i = KIND_NOP;
  logic signed [DATA_W-1:0] push_value_i = '0;
  logic signed [STEP_W-1:0] rotate_step_i = '0;
  logic                     rotate_backward_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] popped_value_o;
  logic [1:0]               status_o;
  logic [CNT_W-1:0]         occupancy_o;

  deque_op_t                ops_to_send[$];
  deque_result_t            results_owed[$];
  logic signed [DATA_W-1:0] ring_model[$];

  deque_op_t   cur_op;
  int unsigned planned_occ = 0;
  int          stim_total = 0;
  int          taken_count = 0;
  int          rx_count = 0;
  int          send_gap = 0;
  int          hold_left = 0;
  int          squeeze_left = 0;
  int          squeeze_at = 150;
  int          mismatch_count = 0;

  circular_deque_with_rotate dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .push_value_i     (push_value_i),
    .rotate_step_i    (rotate_step_i),
    .rotate_backward_i(rotate_backward_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .popped_value_o   (popped_value_o),
    .status_o         (status_o),
    .occupancy_o      (occupancy_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic deque_result_t deque_apply(deque_op_t op);
    deque_result_t r;
    logic [31:0]   mag;
    logic          bk;
    int unsigned   turns;
    r.popped = '0;
    r.status = STAT_OK;
    case (op.kind)
      KIND_PUSH: begin
        if (ring_model.size() >= DEPTH) r.status = STAT_FULL;
        else ring_model.push_back(op.push_v);
      end
      KIND_POP: begin
        if (ring_model.size() == 0) begin
          r.popped = -1;
          r.status = STAT_EMPTY;
        end else begin
          r.popped = ring_model.pop_front();
        end
      end
      KIND_ROT: begin
        if (ring_model.size() != 0) begin
          bk  = op.back;
          mag = op.step;
          // negative step flips direction, magnitude taken unsigned
          if (op.step[STEP_W-1]) begin
            bk  = !bk;
            mag = 32'(-op.step);
          end
          turns = mag % 32'(ring_model.size());
          repeat (turns) begin
            if (bk) ring_model.push_front(ring_model.pop_back());
            else ring_model.push_back(ring_model.pop_front());
          end
        end
      end
      default: ;
    endcase
    r.occ = CNT_W'(ring_model.size());
    return r;
  endfunction

  function automatic bit idling_ok(int done);
    return (done + 150 < stim_total) && ((done / 80) % 4 != 3);
  endfunction

  task automatic plan_op(input kind_e k, input logic [31:0] pv, input logic [31:0] st,
                         input logic bk);
    deque_op_t op;
    op.kind   = k;
    op.push_v = pv;
    op.step   = st;
    op.back   = bk;
    ops_to_send.push_back(op);
    case (k)
      KIND_PUSH: if (planned_occ < DEPTH) planned_occ++;
      KIND_POP:  if (planned_occ != 0) planned_occ--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_step();
    logic [31:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2: s = $urandom_range(0, 2 * planned_occ + 3);
      3:       s = 32'd0 - 32'($urandom_range(1, 2 * planned_occ + 3));
      4:       s = planned_occ * $urandom_range(1, 5);
      5:       s = 32'h8000_0000;
      6:       s = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0001;
      default: s = $urandom();
    endcase
    return s;
  endfunction

  task automatic plan_random_op(input int unsigned push_pct, input int unsigned pop_pct,
                                input int unsigned rot_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      plan_op(KIND_PUSH, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
    else if (r < push_pct + pop_pct)
      plan_op(KIND_POP, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
    else if (r < push_pct + pop_pct + rot_pct)
      plan_op(KIND_ROT, $urandom(), pick_step(), 1'($urandom_range(0, 1)));
    else
      plan_op(KIND_NOP, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        results_owed.push_back(deque_apply(cur_op));
        taken_count <= taken_count + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (ops_to_send.size() != 0) begin
          cur_op = ops_to_send.pop_front();
          kind_i            <= cur_op.kind;
          push_value_i      <= cur_op.push_v;
          rotate_step_i     <= cur_op.step;
          rotate_backward_i <= cur_op.back;
          in_valid_i        <= 1'b1;
          if (idling_ok(taken_count) && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 18);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rx_count <= rx_count + 1;
        if (results_owed.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result %0d: popped %0d status %0d occupancy %0d",
                     rx_count, popped_value_o, status_o, occupancy_o);
        end else begin
          want = results_owed.pop_front();
          if (popped_value_o !== want.popped || status_o !== want.status ||
              occupancy_o !== want.occ) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch on result %0d: popped %0d/%0d status %0d/%0d %s %0d/%0d",
                       rx_count, want.popped, popped_value_o, want.status, status_o,
                       "occupancy (expected/actual)", want.occ, occupancy_o);
          end
        end
      end
      if (squeeze_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (idling_ok(rx_count) && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 17);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk_i) begin
    if (squeeze_left != 0) begin
      squeeze_left <= squeeze_left - 1;
    end else if (rst_ni && rx_count >= squeeze_at && rx_count + 200 < stim_total) begin
      squeeze_left <= 400;
      squeeze_at   <= squeeze_at + 700;
    end
  end

  initial begin
    plan_op(KIND_POP, 32'h0, 32'h0, 1'b0);
    plan_op(KIND_ROT, 32'h0, 32'd5, 1'b0);
    plan_op(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    plan_op(KIND_PUSH, 32'h7FFF_FFFF, 32'h0, 1'b0);
    plan_op(KIND_PUSH, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    plan_op(KIND_PUSH, 32'h0, 32'h0, 1'b0);
    plan_op(KIND_PUSH, 32'hFFFF_FFFF, 32'h0, 1'b0);
    plan_op(KIND_PUSH, 32'h1234_5678, 32'h0, 1'b0);
    plan_op(KIND_ROT, 32'h0, 32'd1, 1'b0);
    plan_op(KIND_ROT, 32'h0, 32'd2, 1'b1);
    plan_op(KIND_ROT, 32'h0, 32'hFFFF_FFFF, 1'b0);
    plan_op(KIND_ROT, 32'h0, 32'hFFFF_FFFD, 1'b1);
    plan_op(KIND_ROT, 32'h0, 32'h8000_0000, 1'b0);
    plan_op(KIND_ROT, 32'h0, 32'h8000_0000, 1'b1);
    plan_op(KIND_ROT, 32'h0, 32'h7FFF_FFFF, 1'b1);
    plan_op(KIND_ROT, 32'hFFFF_FFFF, 32'd0, 1'b1);
    plan_op(KIND_ROT, 32'h0, 32'd5, 1'b0);
    plan_op(KIND_NOP, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0);
    repeat (5) plan_op(KIND_POP, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
    plan_op(KIND_POP, 32'h0, 32'h0, 1'b1);
    plan_op(KIND_PUSH, 32'd42, 32'h0, 1'b0);
    plan_op(KIND_ROT, 32'h0, 32'd7, 1'b0);
    plan_op(KIND_POP, 32'h0, 32'h0, 1'b0);

    repeat (250)
      plan_random_op(planned_occ > 48 ? 15 : (planned_occ < 3 ? 55 : 38), 32, 24);

    // push-heavy stretch, then drain back down
    repeat (60) plan_random_op(85, 5, 6);
    while (planned_occ > 16) plan_random_op(3, 94, 2);

    repeat (300)
      plan_random_op(planned_occ > 48 ? 15 : (planned_occ < 3 ? 55 : 38), 32, 24);

    stim_total = ops_to_send.size();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ops_to_send.size() != 0 || in_valid_i || results_owed.size() != 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
